FILE: rtl/psw_pkg.sv
`timescale 1ns / 1ps
package psw_pkg;

   // Result codes
   typedef enum logic [1:0] {
      OUTCOME_WRITE      = 2'd0,
      OUTCOME_NO_CONTEXT = 2'd1,
      OUTCOME_PORT       = 2'd2,
      OUTCOME_OUTSIDE    = 2'd3
   } outcome_type;

   // Register indexes on the CSR port
   localparam logic [1:0] CSR_PRACH_RE_COUNT  = 2'd0;
   localparam logic [1:0] CSR_FIRST_RE_OFFSET = 2'd1;
   localparam logic [1:0] CSR_PORT_LIMIT      = 2'd2;
   localparam logic [1:0] CSR_EAXC_TABLE      = 2'd3;

   localparam int unsigned TABLE_ENTRIES = 4;
   localparam int unsigned EAXC_WIDTH    = 16;

   // After port match: drop reason so far and the window total
   typedef struct packed {
      outcome_type outcome;
      logic [1:0]  port;
      logic [3:0]  sym;
      logic [9:0]  sprb;
      logic [7:0]  nprb;
      logic [12:0] total;
   } match_type;

   // After window size: window PRBs and section position
   typedef struct packed {
      outcome_type outcome;
      logic [1:0]  port;
      logic [3:0]  sym;
      logic [9:0]  sprb;
      logic [7:0]  nprb;
      logic [12:0] total;
      logic [8:0]  win_prbs;
      logic [8:0]  data_start_prb;
      logic [10:0] sec_end_prb;
      logic [13:0] sec_start_re;
   } span_type;

   // After window check: PRBs to write and tail trim
   typedef struct packed {
      outcome_type outcome;
      logic [1:0]  port;
      logic [3:0]  sym;
      logic [13:0] sec_start_re;
      logic [8:0]  nwrite;
      logic [3:0]  tail_re;
      logic        tail_apply;
   } window_type;

   // After first trim: buffer start, IQ offset, untrimmed length
   typedef struct packed {
      outcome_type outcome;
      logic [1:0]  port;
      logic [3:0]  sym;
      logic [13:0] buf_first_re;
      logic [11:0] iq_start;
      logic [12:0] sec_re;
   } extent_type;

   // Divide a value below 8192 by 12: drop two bits (by 4), then times 683 over 2048 (by 3)
   function automatic logic [9:0] div12(input logic [12:0] value);
      logic [20:0] prod;
      prod = 21'(value[12:2]) * 21'd683;
      return prod[20:11];
   endfunction

endpackage

FILE: rtl/psw_if.sv
`timescale 1ns / 1ps
interface psw_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] eaxc_id;
   logic        context_found;
   logic [3:0]  symbol_index;
   logic [9:0]  section_start_prb;
   logic [7:0]  section_prb_count;

   modport source (output valid, eaxc_id, context_found, symbol_index,
                   section_start_prb, section_prb_count, input ready);
   modport sink (input valid, eaxc_id, context_found, symbol_index,
                 section_start_prb, section_prb_count, output ready);
endinterface

interface psw_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  outcome;
   logic [1:0]  port_index;
   logic [3:0]  symbol_out;
   logic [13:0] buffer_start_re;
   logic [11:0] iq_first_re;
   logic [9:0]  iq_re_count;

   modport source (output valid, outcome, port_index, symbol_out, buffer_start_re,
                   iq_first_re, iq_re_count, input ready);
   modport sink (input valid, outcome, port_index, symbol_out, buffer_start_re,
                 iq_first_re, iq_re_count, output ready);
endinterface

FILE: rtl/psw_match.sv
`timescale 1ns / 1ps
module psw_match
   import psw_pkg::*;
#(
   parameter int unsigned MAX_PORTS = 4
) (
   input  logic        clock,
   input  logic        reset,
   psw_req_if.sink     req_chan,
   input  logic [9:0]  prach_re_count,
   input  logic [11:0] first_re_offset,
   input  logic [2:0]  port_limit,
   input  logic [63:0] eaxc_table,
   output logic        out_valid,
   input  logic        out_ready,
   output match_type   out_data
);

   logic        valid_ff;
   match_type   data_ff;
   match_type   data_in;
   logic        found;
   logic [1:0]  port;
   logic        stage_ready;

   // Search the table, lowest matching entry wins
   always_comb begin
      found = 1'b0;
      port  = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (i < int'(MAX_PORTS) &&
             eaxc_table[i*EAXC_WIDTH +: EAXC_WIDTH] == req_chan.eaxc_id) begin
            found = 1'b1;
            port  = 2'(i);
         end
      end
   end

   // Classify context and port, sum the window extent
   always_comb begin
      data_in.port  = port;
      data_in.sym   = req_chan.symbol_index;
      data_in.sprb  = req_chan.section_start_prb;
      data_in.nprb  = req_chan.section_prb_count;
      data_in.total = 13'(prach_re_count) + 13'(first_re_offset);
      if (!req_chan.context_found) begin
         data_in.outcome = OUTCOME_NO_CONTEXT;
      end else if (!found || {1'b0, port} >= port_limit) begin
         data_in.outcome = OUTCOME_PORT;
      end else begin
         data_in.outcome = OUTCOME_WRITE;
      end
   end

   assign stage_ready    = !valid_ff || out_ready;
   assign req_chan.ready = stage_ready;

   // Advance the stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (stage_ready) begin
         valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && stage_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: rtl/psw_window.sv
`timescale 1ns / 1ps
module psw_window
   import psw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [11:0] first_re_offset,
   input  logic        in_valid,
   output logic        in_ready,
   input  match_type   in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output window_type  out_data
);

   logic        span_valid_ff;
   span_type    span_ff;
   span_type    span_in;
   logic        span_ready;
   logic        win_valid_ff;
   window_type  win_ff;
   window_type  win_in;
   logic        win_ready;
   logic [9:0]  win_prbs_q;
   logic [9:0]  dsp_q;
   logic [12:0] win_re;
   logic        outside;

   // Window size in PRBs (ceiling) and first PRB that holds PRACH data
   always_comb begin
      win_prbs_q             = div12(in_data.total + 13'd11);
      dsp_q                  = div12(13'(first_re_offset));
      span_in.outcome        = in_data.outcome;
      span_in.port           = in_data.port;
      span_in.sym            = in_data.sym;
      span_in.sprb           = in_data.sprb;
      span_in.nprb           = in_data.nprb;
      span_in.total          = in_data.total;
      span_in.win_prbs       = win_prbs_q[8:0];
      span_in.data_start_prb = dsp_q[8:0];
      span_in.sec_end_prb    = 11'(in_data.sprb) + 11'(in_data.nprb);
      span_in.sec_start_re   = 14'({in_data.sprb, 3'b000}) + 14'({in_data.sprb, 2'b00});
   end

   // Check overlap, count PRBs to write, find the unused tail
   always_comb begin
      win_re  = 13'({span_ff.win_prbs, 3'b000}) + 13'({span_ff.win_prbs, 2'b00});
      outside = (span_ff.sprb >= {1'b0, span_ff.win_prbs}) ||
                (span_ff.sec_end_prb <= {2'b00, span_ff.data_start_prb});
      win_in.port         = span_ff.port;
      win_in.sym          = span_ff.sym;
      win_in.sec_start_re = span_ff.sec_start_re;
      win_in.tail_re      = 4'(win_re - span_ff.total);
      win_in.tail_apply   = span_ff.sec_end_prb >= {2'b00, span_ff.win_prbs};
      if (win_in.tail_apply) begin
         win_in.nwrite = 9'({1'b0, span_ff.win_prbs} - span_ff.sprb);
      end else begin
         win_in.nwrite = 9'(span_ff.nprb);
      end
      if (span_ff.outcome == OUTCOME_WRITE && outside) begin
         win_in.outcome = OUTCOME_OUTSIDE;
      end else begin
         win_in.outcome = span_ff.outcome;
      end
   end

   assign win_ready  = !win_valid_ff || out_ready;
   assign span_ready = !span_valid_ff || win_ready;
   assign in_ready   = span_ready;

   // Advance both stages
   always_ff @(posedge clock) begin
      if (reset) begin
         span_valid_ff <= 1'b0;
         win_valid_ff  <= 1'b0;
      end else begin
         if (span_ready) begin
            span_valid_ff <= in_valid;
         end
         if (win_ready) begin
            win_valid_ff <= span_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && span_ready) begin
         span_ff <= span_in;
      end
      if (span_valid_ff && win_ready) begin
         win_ff <= win_in;
      end
   end

   assign out_valid = win_valid_ff;
   assign out_data  = win_ff;

endmodule

FILE: rtl/psw_extent.sv
`timescale 1ns / 1ps
module psw_extent
   import psw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [9:0]  prach_re_count,
   input  logic [11:0] first_re_offset,
   input  logic        in_valid,
   output logic        in_ready,
   input  window_type  in_data,
   psw_rsp_if.source   rsp_chan
);

   logic        ext_valid_ff;
   extent_type  ext_ff;
   extent_type  ext_in;
   logic        ext_ready;
   logic        rsp_valid_ff;
   logic        rsp_ready_int;
   logic [12:0] sec_re_full;
   logic [13:0] fro_wide;
   logic [12:0] sec_re_trim;
   logic [12:0] iq_start_wide;
   logic [9:0]  iq_size;
   logic [1:0]  outcome_in;
   logic [1:0]  outcome_ff;
   logic [1:0]  port_ff;
   logic [3:0]  sym_ff;
   logic [13:0] buf_first_ff;
   logic [11:0] iq_first_ff;
   logic [9:0]  iq_count_ff;

   // Buffer start, IQ offset and length trimmed by the window tail
   always_comb begin
      fro_wide    = 14'(first_re_offset);
      sec_re_full = 13'({in_data.nwrite, 3'b000}) + 13'({in_data.nwrite, 2'b00});
      ext_in.outcome = in_data.outcome;
      ext_in.port    = in_data.port;
      ext_in.sym     = in_data.sym;
      if (in_data.tail_apply) begin
         ext_in.sec_re = (sec_re_full > 13'(in_data.tail_re)) ?
                         sec_re_full - 13'(in_data.tail_re) : '0;
      end else begin
         ext_in.sec_re = sec_re_full;
      end
      if (in_data.sec_start_re > fro_wide) begin
         ext_in.buf_first_re = in_data.sec_start_re - fro_wide;
      end else begin
         ext_in.buf_first_re = '0;
      end
      if (in_data.sec_start_re < fro_wide) begin
         ext_in.iq_start = 12'(fro_wide - in_data.sec_start_re);
      end else begin
         ext_in.iq_start = '0;
      end
   end

   // Drop the IQ head and clamp to the buffer size
   always_comb begin
      iq_start_wide = 13'(ext_ff.iq_start);
      sec_re_trim   = (ext_ff.sec_re > iq_start_wide) ? ext_ff.sec_re - iq_start_wide : '0;
      iq_size       = (sec_re_trim < 13'(prach_re_count)) ? 10'(sec_re_trim) : prach_re_count;
      outcome_in    = ext_ff.outcome;
   end

   assign rsp_ready_int = !rsp_valid_ff || rsp_chan.ready;
   assign ext_ready     = !ext_valid_ff || rsp_ready_int;
   assign in_ready      = ext_ready;

   // Advance both stages
   always_ff @(posedge clock) begin
      if (reset) begin
         ext_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ext_ready) begin
            ext_valid_ff <= in_valid;
         end
         if (rsp_ready_int) begin
            rsp_valid_ff <= ext_valid_ff;
         end
      end
   end

   // Hold the response; a drop clears every field but the reason
   always_ff @(posedge clock) begin
      if (in_valid && ext_ready) begin
         ext_ff <= ext_in;
      end
      if (ext_valid_ff && rsp_ready_int) begin
         outcome_ff <= outcome_in;
         if (ext_ff.outcome == OUTCOME_WRITE) begin
            port_ff      <= ext_ff.port;
            sym_ff       <= ext_ff.sym;
            buf_first_ff <= ext_ff.buf_first_re;
            iq_first_ff  <= ext_ff.iq_start;
            iq_count_ff  <= iq_size;
         end else begin
            port_ff      <= '0;
            sym_ff       <= '0;
            buf_first_ff <= '0;
            iq_first_ff  <= '0;
            iq_count_ff  <= '0;
         end
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.outcome         = outcome_ff;
   assign rsp_chan.port_index      = port_ff;
   assign rsp_chan.symbol_out      = sym_ff;
   assign rsp_chan.buffer_start_re = buf_first_ff;
   assign rsp_chan.iq_first_re     = iq_first_ff;
   assign rsp_chan.iq_re_count     = iq_count_ff;

endmodule

FILE: rtl/prach_section_window_mapper.sv
`timescale 1ns / 1ps
// PRACH section window mapper.
// req_chan takes one uplink section header per request (eAxC id, context flag,
// symbol, start PRB, PRB count); rsp_chan returns one result per request, in
// order: a write command (port, symbol, buffer start RE, IQ offset, RE count)
// or a drop with its reason, all other fields zero.
// The csr_ port writes the window registers (RE count, first RE offset, port
// limit, eAxC table) by index; write them only while no request is in flight.
// Five register stages: port match, window size (division by 12 as a
// reciprocal multiply), overlap check, buffer extent, response register.
// Throughput is one request per cycle while rsp_chan is ready; each stage
// advances whenever the stage after it is empty or moving, so bubbles close up
// and a full pipeline holds five requests.
// When rsp_chan stalls, the stages fill and req_chan.ready falls; nothing is
// dropped or repeated.
// Reset empties the pipeline and loads the registers with RE count 839,
// offset 0, port limit 0 and an all-zero eAxC table.
module prach_section_window_mapper
   import psw_pkg::*;
#(
   parameter int unsigned MAX_PORTS = 4
) (
   input  logic        clock,
   input  logic        reset,
   psw_req_if.sink     req_chan,
   psw_rsp_if.source   rsp_chan,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);

   logic [9:0]  prach_re_count_ff;
   logic [11:0] first_re_offset_ff;
   logic [2:0]  port_limit_ff;
   logic [63:0] eaxc_table_ff;

   logic        match_valid;
   logic        match_ready;
   match_type   match_data;
   logic        win_valid;
   logic        win_ready;
   window_type  win_data;

   // Write the window registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prach_re_count_ff  <= 10'd839;
         first_re_offset_ff <= '0;
         port_limit_ff      <= '0;
         eaxc_table_ff      <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_PRACH_RE_COUNT:  prach_re_count_ff  <= csr_write_data[9:0];
            CSR_FIRST_RE_OFFSET: first_re_offset_ff <= csr_write_data[11:0];
            CSR_PORT_LIMIT:      port_limit_ff      <= csr_write_data[2:0];
            CSR_EAXC_TABLE:      eaxc_table_ff      <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   psw_match #(
      .MAX_PORTS (MAX_PORTS)
   ) u_match (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .prach_re_count  (prach_re_count_ff),
      .first_re_offset (first_re_offset_ff),
      .port_limit      (port_limit_ff),
      .eaxc_table      (eaxc_table_ff),
      .out_valid       (match_valid),
      .out_ready       (match_ready),
      .out_data        (match_data)
   );

   psw_window u_window (
      .clock           (clock),
      .reset           (reset),
      .first_re_offset (first_re_offset_ff),
      .in_valid        (match_valid),
      .in_ready        (match_ready),
      .in_data         (match_data),
      .out_valid       (win_valid),
      .out_ready       (win_ready),
      .out_data        (win_data)
   );

   psw_extent u_extent (
      .clock           (clock),
      .reset           (reset),
      .prach_re_count  (prach_re_count_ff),
      .first_re_offset (first_re_offset_ff),
      .in_valid        (win_valid),
      .in_ready        (win_ready),
      .in_data         (win_data),
      .rsp_chan        (rsp_chan)
   );

   // A drop carries nothing but its reason
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.outcome != OUTCOME_WRITE) |->
      (rsp_chan.port_index == '0 && rsp_chan.symbol_out == '0 &&
       rsp_chan.buffer_start_re == '0 && rsp_chan.iq_first_re == '0 &&
       rsp_chan.iq_re_count == '0))
      else $error("dropped section carries nonzero fields");

   // A write never copies more than the buffer holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.outcome == OUTCOME_WRITE) |->
      (rsp_chan.iq_re_count <= prach_re_count_ff))
      else $error("write count exceeds PRACH RE count");

   // A write targets a usable port
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.outcome == OUTCOME_WRITE) |->
      ({1'b0, rsp_chan.port_index} < port_limit_ff))
      else $error("write to port beyond port limit");

   // Reset empties the pipeline
   assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("response valid right after reset");

endmodule
